>>> rtl/cpetr_pkg.sv
`default_nettype none
package cpetr_pkg;

  localparam int FRAME_DEPTH_DEF = 10;
  localparam int TIME_TABLE_BINS = 100;
  localparam int POS_W = 6;

  // register indexes
  localparam logic [2:0] REG_FIRST_SAMPLE    = 3'd0;
  localparam logic [2:0] REG_SAMPLE_COUNT    = 3'd1;
  localparam logic [2:0] REG_PRESAMPLE_COUNT = 3'd2;
  localparam logic [2:0] REG_ADC_SAT_LEVEL   = 3'd3;
  localparam logic [2:0] REG_SAT_RATIO       = 3'd4;
  localparam logic [2:0] REG_CHECK_SAT       = 3'd5;
  localparam logic [2:0] REG_RECOVER_SAT     = 3'd6;

  localparam logic [3:0]  RST_FIRST_SAMPLE    = 4'd4;
  localparam logic [3:0]  RST_SAMPLE_COUNT    = 4'd2;
  localparam logic [3:0]  RST_PRESAMPLE_COUNT = 4'd4;
  localparam logic [6:0]  RST_ADC_SAT_LEVEL   = 7'd127;
  localparam logic [15:0] RST_SAT_RATIO       = 16'd256;

  localparam logic signed [18:0] W_ORIGIN_Q16  = 19'sd32810;
  localparam logic signed [23:0] BIN_SCALE_Q16 = 24'sd6558184;
  localparam logic signed [13:0] INVALID_TIME  = 14'h2000;

  // time table in units of 1/400 ns
  localparam int TIME_TABLE [TIME_TABLE_BINS] = '{
    0, 15, 29, 43, 58, 72, 86, 100, 114, 128,
    142, 156, 170, 184, 198, 212, 226, 240, 254, 268,
    283, 297, 312, 326, 341, 356, 371, 386, 401, 417,
    433, 449, 465, 482, 498, 516, 533, 552, 570, 590,
    610, 631, 653, 676, 701, 728, 757, 790, 829, 880,
    7652, 8435, 8631, 8756, 8849, 8924, 8988, 9044, 9093, 9138,
    9179, 9217, 9253, 9286, 9317, 9347, 9375, 9402, 9428, 9453,
    9477, 9500, 9522, 9544, 9565, 9586, 9606, 9626, 9645, 9664,
    9682, 9700, 9718, 9735, 9752, 9769, 9786, 9802, 9818, 9834,
    9850, 9866, 9881, 9896, 9911, 9926, 9941, 9956, 9971, 9985
  };

  typedef struct packed {
    logic load_in;
    logic mul;
    logic acc;
    logic rd0;
    logic rd1;
    logic rd2;
    logic prep;
    logic div_start;
    logic t1;
    logic t2;
    logic t3;
    logic t4;
    logic t5;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_busy;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/cpetr_div.sv
`default_nettype none
module cpetr_div #(
  parameter int DW    = 50,
  parameter int VW    = 34,
  parameter int QBITS = 18
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DW-1:0]    dividend,
  input  logic [VW-1:0]    divisor,
  output logic             busy,
  output logic [QBITS-1:0] quotient,
  output logic             rem_nz
);
  localparam int W    = VW + QBITS;
  localparam int CNTW = $clog2(QBITS + 1);

  logic [W-1:0]    rem;
  logic [W-1:0]    dsh;
  logic [CNTW-1:0] cnt;

  // one quotient bit a cycle, quotient assumed below 2**QBITS
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(QBITS);
    end else if (busy) begin
      if (cnt == CNTW'(1)) busy <= 1'b0;
      cnt <= cnt - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= W'(dividend);
      dsh <= W'(divisor) << (QBITS - 1);
    end else if (busy) begin
      if (rem >= dsh) begin
        rem      <= rem - dsh;
        quotient <= {quotient[QBITS-2:0], 1'b1};
      end else begin
        quotient <= {quotient[QBITS-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  assign rem_nz = |rem;
endmodule
`default_nettype wire

>>> rtl/cpetr_ctrl.sv
`default_nettype none
module cpetr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output cpetr_pkg::cmd_t    cmd,
  input  cpetr_pkg::status_t sts
);
  import cpetr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_ACC   = 4'd2;
  localparam logic [3:0] S_RD0   = 4'd3;
  localparam logic [3:0] S_RD1   = 4'd4;
  localparam logic [3:0] S_RD2   = 4'd5;
  localparam logic [3:0] S_PREP  = 4'd6;
  localparam logic [3:0] S_START = 4'd7;
  localparam logic [3:0] S_DIVW  = 4'd8;
  localparam logic [3:0] S_T1    = 4'd9;
  localparam logic [3:0] S_T2    = 4'd10;
  localparam logic [3:0] S_T3    = 4'd11;
  localparam logic [3:0] S_T4    = 4'd12;
  localparam logic [3:0] S_T5    = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load_in   = s_tvalid && s_tready;
    cmd.mul       = (state == S_MUL);
    cmd.acc       = (state == S_ACC);
    cmd.rd0       = (state == S_RD0);
    cmd.rd1       = (state == S_RD1);
    cmd.rd2       = (state == S_RD2);
    cmd.prep      = (state == S_PREP);
    cmd.div_start = (state == S_START);
    cmd.t1        = (state == S_T1);
    cmd.t2        = (state == S_T2);
    cmd.t3        = (state == S_T3);
    cmd.t4        = (state == S_T4);
    cmd.t5        = (state == S_T5);
    cmd.out_load  = (state == S_OUT) && (!m_tvalid || m_tready);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_tvalid) state_next = S_MUL;
      S_MUL:   state_next = S_ACC;
      S_ACC:   state_next = sts.last ? S_RD0 : S_IDLE;
      S_RD0:   state_next = S_RD1;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_PREP;
      S_PREP:  state_next = S_START;
      S_START: state_next = S_DIVW;
      S_DIVW:  if (!sts.div_busy) state_next = S_T1;
      S_T1:    state_next = S_T2;
      S_T2:    state_next = S_T3;
      S_T3:    state_next = S_T4;
      S_T4:    state_next = S_T5;
      S_T5:    state_next = S_OUT;
      S_OUT:   if (cmd.out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> rtl/cpetr_dp.sv
`default_nettype none
module cpetr_dp #(
  parameter int FRAME_DEPTH = cpetr_pkg::FRAME_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cpetr_pkg::cmd_t    cmd,
  output cpetr_pkg::status_t sts,
  input  logic [71:0]        s_tdata,
  input  logic               s_tlast,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic [47:0]        m_tdata,
  output logic [2:0]         m_tuser
);
  import cpetr_pkg::*;

  localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int PW = $clog2(FRAME_DEPTH + 1);
  localparam logic [POS_W-1:0] DEPTH_C = POS_W'(FRAME_DEPTH);

  // configuration
  logic [3:0]  first_sample;
  logic [3:0]  sample_count;
  logic [3:0]  presample_count;
  logic [6:0]  adc_sat_level;
  logic [15:0] sat_ratio;
  logic        check_sat;
  logic        recover_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sample    <= RST_FIRST_SAMPLE;
      sample_count    <= RST_SAMPLE_COUNT;
      presample_count <= RST_PRESAMPLE_COUNT;
      adc_sat_level   <= RST_ADC_SAT_LEVEL;
      sat_ratio       <= RST_SAT_RATIO;
      check_sat       <= 1'b1;
      recover_sat     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_SAMPLE:    first_sample    <= cfg_data[3:0];
        REG_SAMPLE_COUNT:    sample_count    <= cfg_data[3:0];
        REG_PRESAMPLE_COUNT: presample_count <= cfg_data[3:0];
        REG_ADC_SAT_LEVEL:   adc_sat_level   <= cfg_data[6:0];
        REG_SAT_RATIO:       sat_ratio       <= cfg_data;
        REG_CHECK_SAT:       check_sat       <= cfg_data[0];
        REG_RECOVER_SAT:     recover_sat     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input item
  logic [19:0] charge, ped, gain;
  logic [6:0]  adc;
  logic        last_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      charge <= s_tdata[19:0];
      ped    <= s_tdata[39:20];
      gain   <= s_tdata[59:40];
      adc    <= s_tdata[66:60];
      last_r <= s_tlast;
    end
  end

  // sample energy, rounded to q.8
  logic signed [20:0] diff;
  logic signed [41:0] prod;
  logic signed [31:0] e_new;

  assign diff = $signed({1'b0, charge}) - $signed({1'b0, ped});
  assign prod = 42'(diff) * 42'($signed({1'b0, gain}));

  always_ff @(posedge clk) begin
    if (cmd.mul) e_new <= 32'((prod + 42'sd512) >>> 10);
  end

  // frame state
  logic [PW-1:0]      pos;
  logic signed [39:0] sum;
  logic signed [31:0] peak;
  logic [PW-1:0]      peak_pos;
  logic               found;
  logic               win_sat;
  logic [1:0]         flags;

  logic [POS_W-1:0] pos_c, fs_c, win_end, pk_c;
  logic             in_win, sat, stored;

  assign pos_c   = POS_W'(pos);
  assign fs_c    = POS_W'(first_sample);
  assign win_end = fs_c + POS_W'(sample_count);
  assign pk_c    = POS_W'(peak_pos);
  assign in_win  = (pos_c >= fs_c) && (pos_c < win_end);
  assign sat     = (adc >= adc_sat_level);
  assign stored  = (pos_c < DEPTH_C);

  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      pos      <= '0;
      sum      <= '0;
      found    <= 1'b0;
      win_sat  <= 1'b0;
      flags    <= 2'b00;
    end else if (cmd.acc && stored) begin
      if (in_win) begin
        sum <= sum + 40'(e_new);
        if (!found || e_new > peak) begin
          found    <= 1'b1;
          peak_pos <= pos;
          peak     <= e_new;
        end
        if (sat) win_sat <= 1'b1;
      end
      if (sat && pos_c == fs_c) flags[0] <= 1'b1;
      if (sat && pos_c == fs_c + POS_W'(1)) flags[1] <= 1'b1;
      pos <= pos + PW'(1);
    end
  end

  // sample energy store
  logic signed [31:0] store [FRAME_DEPTH];
  logic signed [31:0] e_t0, e_a, e_t2, e1, e2;
  logic [AW-1:0]      pk_a, pm1_a, pp1_a, fs_a, fs1_a;

  assign pk_a  = peak_pos[AW-1:0];
  assign pm1_a = pk_a - AW'(1);
  assign pp1_a = pk_a + AW'(1);
  assign fs_a  = AW'(first_sample);
  assign fs1_a = AW'({1'b0, first_sample} + 5'd1);

  always_ff @(posedge clk) begin
    if (cmd.acc && stored) store[pos[AW-1:0]] <= e_new;
    if (cmd.rd0) begin
      e_t0 <= store[pm1_a];
      e_a  <= store[pk_a];
    end
    if (cmd.rd1) begin
      e_t2 <= store[pp1_a];
      e1   <= store[fs_a];
    end
    if (cmd.rd2) e2 <= store[fs1_a];
  end

  // weights and recovery operands
  logic [31:0]        t0u, au, t2u;
  logic [33:0]        num, den;
  logic signed [48:0] e1r;
  logic signed [39:0] a256;
  logic [39:0]        a256u;
  logic               rec_cmp;

  assign t0u   = e_t0[31] ? 32'(-e_t0) : 32'(e_t0);
  assign au    = e_a[31]  ? 32'(-e_a)  : 32'(e_a);
  assign t2u   = e_t2[31] ? 32'(-e_t2) : 32'(e_t2);
  assign a256  = {e2, 8'b0};
  assign a256u = a256[39] ? 40'(-a256) : 40'(a256);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num <= 34'(au) + {1'b0, t2u, 1'b0};
      den <= 34'(t0u) + 34'(au) + 34'(t2u);
      e1r <= 49'(e1) * 49'($signed({1'b0, sat_ratio}));
    end
    if (cmd.div_start) rec_cmp <= 50'(a256) > 50'(e1r);
  end

  // dividers
  logic        tbusy, rbusy, t_nz, r_nz;
  logic [17:0] w16;
  logic [39:0] rq;

  cpetr_div #(.DW(50), .VW(34), .QBITS(18)) u_tdiv (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend({num, 16'b0}), .divisor(den),
    .busy(tbusy), .quotient(w16), .rem_nz(t_nz)
  );

  cpetr_div #(.DW(40), .VW(16), .QBITS(40)) u_rdiv (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(a256u), .divisor(sat_ratio),
    .busy(rbusy), .quotient(rq), .rem_nz(r_nz)
  );

  assign sts.div_busy = tbusy || rbusy;
  assign sts.last     = last_r;

  // time chain
  logic signed [18:0] wd;
  logic signed [43:0] flx;
  logic signed [40:0] fq;
  logic signed [41:0] e_rec;

  assign wd = (den == '0) ? -W_ORIGIN_Q16 : $signed({1'b0, w16}) - W_ORIGIN_Q16;
  assign fq = a256[39] ? -(41'(rq) + 41'(r_nz)) : 41'(rq);

  always_ff @(posedge clk) begin
    if (cmd.t1) begin
      flx   <= 44'(wd) * 44'(BIN_SCALE_Q16);
      e_rec <= 42'(e2) + 42'(fq);
    end
  end

  logic [11:0]        idx;
  logic [6:0]         i7;
  logic               edge_hi, edge_lo;
  logic signed [15:0] ybase, slope;
  logic signed [32:0] xmul;
  logic signed [47:0] y;

  always_comb begin
    idx     = flx[43:32];
    i7      = idx[6:0];
    edge_hi = !flx[43] && (idx >= 12'(TIME_TABLE_BINS - 1));
    edge_lo = flx[43] && (flx[43:32] != 12'hfff);
    if (flx[43]) begin
      ybase = 16'(TIME_TABLE[0]);
      slope = 16'(TIME_TABLE[1]) - 16'(TIME_TABLE[0]);
      xmul  = flx[32:0];
    end else begin
      ybase = 16'(TIME_TABLE[i7]);
      slope = 16'(TIME_TABLE[7'(i7 + 7'd1)]) - 16'(TIME_TABLE[i7]);
      xmul  = $signed({1'b0, flx[31:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.t2) begin
      if (edge_hi) y <= 48'(TIME_TABLE[TIME_TABLE_BINS - 1]) <<< 32;
      else if (edge_lo) y <= 48'(TIME_TABLE[0]) <<< 32;
      else y <= (48'(ybase) <<< 32) + 48'(slope) * 48'(xmul);
    end
  end

  // offset keeps the divide by 25 on a positive value
  logic signed [5:0]  sdiff;
  logic signed [15:0] zy;
  logic [19:0]        zp;
  logic [14:0]        q0;
  logic [19:0]        rr;
  logic [15:0]        qc;
  logic signed [16:0] qs;
  logic signed [13:0] time_q;

  assign sdiff = $signed({1'b0, pk_c[4:0]}) - $signed({2'b0, presample_count});
  assign zy    = 16'((y + 48'sd53687091200) >>> 32);

  always_ff @(posedge clk) begin
    if (cmd.t3) zp <= 20'(32'(sdiff) * 32'sd10000 + 32'(zy) + 32'sd204800);
    if (cmd.t4) q0 <= 15'((36'(zp) * 36'd41943) >> 20);
  end

  assign rr = zp - 20'(q0) * 20'd25;
  assign qc = 16'(q0) + ((rr >= 20'd25) ? 16'd1 : 16'd0);
  assign qs = $signed({1'b0, qc}) - 17'sd8192;

  always_ff @(posedge clk) begin
    if (cmd.t5) begin
      if (qs > 17'sd8191) time_q <= 14'sd8191;
      else if (qs < -17'sd8192) time_q <= INVALID_TIME;
      else time_q <= 14'(qs);
    end
  end

  // result
  logic               valid, rec_ok;
  logic signed [31:0] e_sum_sat, e_rec_sat;

  assign valid  = found && (pk_c != '0) && (pk_c + POS_W'(1) < pos_c);
  assign rec_ok = recover_sat && (sample_count == 4'd2) && (sat_ratio != '0) &&
                  (fs_c + POS_W'(2) <= pos_c) && (flags == 2'b01) && rec_cmp;

  assign e_sum_sat = (sum > 40'sh007fffffff) ? 32'sh7fffffff :
                     (sum < -40'sh0080000000) ? 32'sh80000000 : 32'(sum);
  assign e_rec_sat = (e_rec > 42'sh0007fffffff) ? 32'sh7fffffff :
                     (e_rec < -42'sh00080000000) ? 32'sh80000000 : 32'(e_rec);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata[31:0]  <= rec_ok ? e_rec_sat : e_sum_sat;
      m_tdata[45:32] <= valid ? time_q : INVALID_TIME;
      m_tdata[47:46] <= 2'b00;
      m_tuser        <= {rec_ok, check_sat && win_sat, valid};
    end
  end
endmodule
`default_nettype wire

>>> rtl/calorimeter_pulse_energy_time_reco_core.sv
// a sample item is accepted, gain multiplied, then stored and accumulated before the next is taken
// after the last sample the result goes through store reads, operand preparation, the
// bit-serial divides and the time chain; the saturation recovery divide, with its 40-bit
// quotient, is the longest step, and the result waits while an earlier one is not taken
// synchronous active-high reset clears the frame state and loads register defaults;
// the sample store is not cleared
`default_nettype none
module calorimeter_pulse_energy_time_reco_core #(
  parameter int FRAME_DEPTH = cpetr_pkg::FRAME_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // sample items
  input  logic        s_tvalid,
  output logic        s_tready,
  // charge_fc[19:0], pedestal_fc[39:20], gain[59:40], adc_code[66:60], zero pad
  input  logic [71:0] s_tdata,
  input  logic        s_tlast,   // last_sample
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // energy[31:0], time_ns[45:32], zero pad
  output logic [47:0] m_tdata,
  // time_valid[0], saturated[1], recovered[2]
  output logic [2:0]  m_tuser,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cpetr_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // registers are always writable
  assign cfg_ready = 1'b1;

  // sequencer: sample steps, store reads, divides, time chain, output hand-off
  cpetr_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cmd(cmd), .sts(sts)
  );

  // arithmetic, sample store and output register
  cpetr_dp #(.FRAME_DEPTH(FRAME_DEPTH)) u_dp (
    .clk(clk), .rst(rst),
    .cmd(cmd), .sts(sts),
    .s_tdata(s_tdata), .s_tlast(s_tlast),
    .cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
  );
endmodule
`default_nettype wire

>>> rtl/cpetr_checker.sv
`default_nettype none
module cpetr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [2:0]  m_tuser
);
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // no result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // an invalid time carries the marker code
  a_time: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[45:32] == 14'h2000)
    else $error("invalid time without marker");

  // a sample is worked on before the next is taken
  a_seq: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
    else $error("sample taken too early");
endmodule

bind calorimeter_pulse_energy_time_reco_core cpetr_checker u_checker (
  .clk(clk), .rst(rst),
  .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

>>> bench/energy_time_checker.sv
`default_nettype none
module energy_time_checker #(
  parameter int FRAME_DEPTH = cpetr_pkg::FRAME_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [71:0] s_tdata,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [47:0] m_tdata,
  input  wire logic [2:0]  m_tuser,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               mismatches,
  output int               pending
);
  import cpetr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NO_PEAK = 31;
  localparam longint ONE_Q32 = 64'sd4294967296;

  typedef struct packed {
    logic [31:0] energy;
    logic [13:0] time_ns;
    logic        time_valid;
    logic        saturated;
    logic        recovered;
  } reco_t;

  reco_t reco_q[$];

  // register copies
  int unsigned first_smp, smp_count, presmp_count, sat_level, sat_ratio;
  bit          check_sat, recover_sat;

  // frame state
  longint      smp_energy [FRAME_DEPTH];
  int unsigned smp_pos, peak_pos;
  longint      energy_acc, peak_val;
  bit          win_sat;
  bit [1:0]    win_adc_flags;

  function automatic longint floor_quot(longint a, longint d);
    if (a >= 0) return a / d;
    return -((-a + d - 1) / d);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void clear_frame();
    smp_pos = 0;
    energy_acc = 0;
    peak_val = -64'sd2147483648;
    peak_pos = NO_PEAK;
    win_sat = 0;
    win_adc_flags = 0;
  endfunction

  // time of the peak from its neighbours, Q4 ns
  function automatic longint peak_time_q4(int unsigned p);
    longint e0, e1, e2, num, den, w16, flx, y, idx, frac, tot;
    e0 = mag(smp_energy[p-1]);
    e1 = mag(smp_energy[p]);
    e2 = mag(smp_energy[p+1]);
    num = e1 + 2 * e2;
    den = e0 + e1 + e2;
    w16 = (den != 0) ? (num * 65536) / den : 0;
    flx = (w16 - longint'(W_ORIGIN_Q16)) * longint'(BIN_SCALE_Q16);
    if (flx >= 0) begin
      idx = flx >>> 32;
      frac = flx & 64'hFFFF_FFFF;
      if (idx >= TIME_TABLE_BINS - 1)
        y = longint'(TIME_TABLE[TIME_TABLE_BINS-1]) * ONE_Q32;
      else
        y = longint'(TIME_TABLE[idx]) * ONE_Q32 +
            longint'(TIME_TABLE[idx+1] - TIME_TABLE[idx]) * frac;
    end else if (-flx >= ONE_Q32) begin
      y = longint'(TIME_TABLE[0]) * ONE_Q32;
    end else begin
      // extrapolate below entry 0
      y = longint'(TIME_TABLE[0]) * ONE_Q32 + longint'(TIME_TABLE[1] - TIME_TABLE[0]) * flx;
    end
    tot = (longint'(p) - longint'(presmp_count)) * 10000 * ONE_Q32 + y;
    return clamp(floor_quot(tot + 25 * (ONE_Q32 / 2), 25 * ONE_Q32), -8192, 8191);
  endfunction

  function automatic void take_sample(logic [71:0] d, logic last);
    longint charge, ped, gain, e, e1, e2, en, tq;
    bit sat, valid, rec;
    reco_t r;
    charge = d[19:0];
    ped = d[39:20];
    gain = d[59:40];
    sat = d[66:60] >= sat_level;
    if (smp_pos < FRAME_DEPTH) begin
      e = ((charge - ped) * gain + 512) >>> 10;
      smp_energy[smp_pos] = e;
      if (smp_pos >= first_smp && smp_pos < first_smp + smp_count) begin
        energy_acc += e;
        // earliest sample wins a tie
        if (peak_pos == NO_PEAK || e > peak_val) begin
          peak_val = e;
          peak_pos = smp_pos;
        end
        if (sat) win_sat = 1;
      end
      if (sat && smp_pos == first_smp) win_adc_flags[0] = 1;
      if (sat && smp_pos == first_smp + 1) win_adc_flags[1] = 1;
      smp_pos++;
    end
    if (!last) return;
    en = clamp(energy_acc, -64'sd2147483648, 64'sd2147483647);
    tq = -8192;
    valid = 0;
    rec = 0;
    if (peak_pos != NO_PEAK && peak_pos != 0 && peak_pos + 1 < smp_pos) begin
      valid = 1;
      tq = peak_time_q4(peak_pos);
    end
    // two-sample recovery of a saturated leading window sample
    if (recover_sat && smp_count == 2 && sat_ratio != 0 && first_smp + 2 <= smp_pos &&
        win_adc_flags == 2'b01) begin
      e1 = smp_energy[first_smp];
      e2 = smp_energy[first_smp+1];
      if (e2 * 256 > e1 * longint'(sat_ratio)) begin
        en = clamp(e2 + floor_quot(e2 * 256, sat_ratio), -64'sd2147483648, 64'sd2147483647);
        rec = 1;
      end
    end
    r.energy = en[31:0];
    r.time_ns = tq[13:0];
    r.time_valid = valid;
    r.saturated = check_sat && win_sat;
    r.recovered = rec;
    reco_q.push_back(r);
    clear_frame();
  endfunction

  function automatic void check_result(reco_t got);
    reco_t want;
    if (reco_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t unexpected result item energy=%0d", $realtime, $signed(got.energy));
      return;
    end
    want = reco_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t result mismatch: energy %0d/%0d time %0d/%0d valid %0b/%0b sat %0b/%0b rec %0b/%0b (exp/act)",
                 $realtime, $signed(want.energy), $signed(got.energy),
                 $signed(want.time_ns), $signed(got.time_ns), want.time_valid, got.time_valid,
                 want.saturated, got.saturated, want.recovered, got.recovered);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      first_smp = RST_FIRST_SAMPLE;
      smp_count = RST_SAMPLE_COUNT;
      presmp_count = RST_PRESAMPLE_COUNT;
      sat_level = RST_ADC_SAT_LEVEL;
      sat_ratio = RST_SAT_RATIO;
      check_sat = 1;
      recover_sat = 0;
      clear_frame();
      reco_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIRST_SAMPLE:    first_smp = cfg_data[3:0];
          REG_SAMPLE_COUNT:    smp_count = cfg_data[3:0];
          REG_PRESAMPLE_COUNT: presmp_count = cfg_data[3:0];
          REG_ADC_SAT_LEVEL:   sat_level = cfg_data[6:0];
          REG_SAT_RATIO:       sat_ratio = cfg_data;
          REG_CHECK_SAT:       check_sat = cfg_data[0];
          REG_RECOVER_SAT:     recover_sat = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) take_sample(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_result({m_tdata[31:0], m_tdata[45:32], m_tuser[0],
                                              m_tuser[1], m_tuser[2]});
    end
    pending = reco_q.size();
  end

endmodule
`default_nettype wire

>>> bench/testbench.sv
`default_nettype none
module testbench;
  import cpetr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;     // charge_fc, pedestal_fc, gain, adc_code, zero pad
  logic        s_tlast;     // last_sample
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;     // energy, time_ns, zero pad
  logic [2:0]  m_tuser;     // time_valid, saturated, recovered
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int mismatches;
  int pending;
  int idle_mode;            // 0 none, 1 sender, 2 receiver, 3 both
  int quiet_cycles;
  int sent_items;

  // current register values, used to shape the frames
  int unsigned cur_first, cur_count, cur_level;
  bit          cur_recover;

  calorimeter_pulse_energy_time_reco_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  energy_time_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls in modes 2 and 3
  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else if (idle_mode == 2)
      m_tready <= $urandom_range(99) >= 49;
    else if (idle_mode == 3)
      m_tready <= $urandom_range(99) >= 34;
    else
      m_tready <= 1'b1;
  end

  // watchdog: cycles with no item moving on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // register write, valid stays high for back-to-back writes
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic load_settings(int unsigned fs, int unsigned sc, int unsigned ps,
                               int unsigned lvl, int unsigned ratio, bit chk, bit rec);
    write_reg(REG_FIRST_SAMPLE, 16'(fs));
    write_reg(REG_SAMPLE_COUNT, 16'(sc));
    write_reg(REG_PRESAMPLE_COUNT, 16'(ps));
    write_reg(REG_ADC_SAT_LEVEL, 16'(lvl));
    write_reg(REG_SAT_RATIO, 16'(ratio));
    write_reg(REG_CHECK_SAT, 16'(chk));
    write_reg(REG_RECOVER_SAT, 16'(rec));
    cfg_valid <= 1'b0;
    cur_first = fs;
    cur_count = sc;
    cur_level = lvl;
    cur_recover = rec;
  endtask

  // one sample item; valid is only lowered in a sender gap
  task automatic send_sample(logic [19:0] charge, logic [19:0] ped, logic [19:0] gain,
                             logic [6:0] adc, logic last);
    bit ok;
    int pct;
    pct = (idle_mode == 1) ? 49 : (idle_mode == 3) ? 34 : 0;
    while ($urandom_range(99) < pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= 72'({$urandom, $urandom, $urandom});
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, adc, gain, ped, charge};
    s_tlast <= last;
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    sent_items++;
  endtask

  // wait for every result, then let the block settle before a register write
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // random frame, mostly shaped around the summing window
  task automatic send_frame();
    int unsigned len, amp, ped;
    logic [19:0] charge, pd, gain;
    logic [6:0] adc;
    if ($urandom_range(9) < 7)
      len = cur_first + cur_count + $urandom_range(3);
    else
      len = $urandom_range(1, 13);
    if (len > 13) len = 13;
    if (len == 0) len = 1;
    amp = $urandom_range(1, 200000);
    for (int unsigned i = 0; i < len; i++) begin
      ped = $urandom_range(0, 4000);
      pd = 20'(ped);
      charge = 20'(ped + $urandom_range(0, amp) - (($urandom_range(9) == 0) ? 2000 : 0));
      gain = 20'($urandom_range(0, 1 << 17));
      if ($urandom_range(9) == 0) begin
        charge = 20'($urandom);
        pd = 20'($urandom);
        gain = 20'($urandom);
      end
      // saturated samples, steered toward the window start when recovery is on
      if (cur_recover && i == cur_first && $urandom_range(3) != 0)
        adc = 7'($urandom_range(cur_level, 127));
      else if (cur_recover && i == cur_first + 1 && cur_level > 0 && $urandom_range(3) != 0)
        adc = 7'($urandom_range(0, cur_level - 1));
      else
        adc = 7'($urandom_range(127));
      send_sample(charge, pd, gain, adc, i == len - 1);
    end
  endtask

  initial begin
    int unsigned set_fs [9] = '{0, 15, 3, 1, 4, 0, 2, 5, 4};
    int unsigned set_sc [9] = '{10, 0, 2, 5, 2, 3, 8, 2, 2};
    int unsigned set_ps [9] = '{0, 10, 2, 3, 4, 7, 1, 5, 15};
    int unsigned set_lv [9] = '{0, 127, 100, 64, 90, 50, 120, 80, 70};
    int unsigned set_rt [9] = '{1, 65535, 300, 128, 65535, 256, 512, 0, 40};
    bit          set_ck [9] = '{1, 0, 1, 1, 1, 0, 1, 1, 1};
    bit          set_rc [9] = '{1, 0, 1, 0, 1, 1, 0, 1, 1};
    idle_mode = 0;
    sent_items = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames under reset settings, recovery enabled
    load_settings(4, 2, 4, 127, 256, 1, 1);
    // field extremes: most negative and most positive sample energy
    send_sample(20'd0, 20'hFFFFF, 20'hFFFFF, 7'd0, 1'b0);
    send_sample(20'hFFFFF, 20'd0, 20'hFFFFF, 7'd127, 1'b0);
    send_sample(20'hFFFFF, 20'd0, 20'hFFFFF, 7'd127, 1'b1);
    // single sample frame, window empty of stored samples
    send_sample(20'd100, 20'd10, 20'd65536, 7'd5, 1'b1);
    // recovery: first window sample saturated, second not, peak on the second window sample
    for (int i = 0; i < 7; i++)
      send_sample(20'd1000 + ((i == 5) ? 20'd40000 : 20'd0) + ((i == 4) ? 20'd200 : 20'd0),
                  20'd1000, 20'd65536, (i == 4) ? 7'd127 : 7'd3, i == 6);
    // long frame: samples past the store depth are dropped, peak at the last window sample
    for (int i = 0; i < 12; i++)
      send_sample(20'd5000 + 20'(i * 3000), 20'd200, 20'd70000, 7'(i * 10), i == 11);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      idle_mode = ph % 4;
      load_settings(set_fs[ph], set_sc[ph], set_ps[ph], set_lv[ph], set_rt[ph],
                    set_ck[ph], set_rc[ph]);
      while (sent_items < 23 + (ph + 1) * 125)
        send_frame();
      drain();
    end

    if (mismatches == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
